@@ hw/rtl/i2c_master_transaction_sequencer_unit_defines.svh @@
// Assertion macros for the I2C master transaction sequencer checker.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define I2CMTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define I2CMTS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/i2cmts_pkg.sv @@
// Shared types and codes of the I2C master transaction sequencer.
`timescale 1ns / 1ps

package i2cmts_pkg;

  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_TXBYTE = 3'd1;
  localparam logic [2:0] OP_WDONE  = 3'd2;
  localparam logic [2:0] OP_RDONE  = 3'd3;
  localparam logic [2:0] OP_CDONE  = 3'd4;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_RSTART = 3'd2;
  localparam logic [2:0] CMD_RACK   = 3'd3;
  localparam logic [2:0] CMD_RNACK  = 3'd4;
  localparam logic [2:0] CMD_STOP   = 3'd5;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_OK   = 2'd1;
  localparam logic [1:0] STATUS_NACK = 2'd2;

  localparam logic READ_BIT  = 1'b1;
  localparam logic WRITE_BIT = 1'b0;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  slave_addr;
    logic [7:0]  send_len;
    logic [15:0] recv_len;
    logic [7:0]  tx_byte;
    logic        nack;
    logic [7:0]  bus_rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [7:0] bus_byte;
    logic       tx_request;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [1:0] status;
  } result_t;

endpackage

@@ hw/rtl/i2cmts_in_reg.sv @@
// Input register stage: holds one accepted word until the sequencer takes it.
`timescale 1ns / 1ps

module i2cmts_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  i2cmts_pkg::item_t   item,
  output logic                item_stall,
  input  logic                ready,
  output logic                hold_valid,
  output i2cmts_pkg::item_t   hold_item
);
  import i2cmts_pkg::*;

  logic  full;
  logic  full_next;
  item_t word;
  logic  accept;

  assign item_stall = full && !ready;
  assign accept     = item_valid && !item_stall;
  assign hold_valid = full;
  assign hold_item  = word;

  always_comb begin
    if (accept) begin
      full_next = 1'b1;
    end else if (ready) begin
      full_next = 1'b0;
    end else begin
      full_next = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
      if (accept) begin
        word <= item;
      end
    end
  end

endmodule

@@ hw/rtl/i2cmts_seq.sv @@
// Transaction state machine and result register.
`timescale 1ns / 1ps

module i2cmts_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold_valid,
  input  i2cmts_pkg::item_t   hold_item,
  output logic                ready,
  output logic                result_valid,
  input  logic                result_stall,
  output i2cmts_pkg::result_t result
);
  import i2cmts_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ADDR_W    = 4'd1,
    PH_WAIT_HOST = 4'd2,
    PH_DATA_W    = 4'd3,
    PH_RSTART    = 4'd4,
    PH_ADDR_R    = 4'd5,
    PH_READ      = 4'd6,
    PH_STOP      = 4'd7
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [6:0]  target_addr;
  logic [6:0]  target_addr_next;
  logic [7:0]  write_total;
  logic [7:0]  write_total_next;
  logic [15:0] read_total;
  logic [15:0] read_total_next;
  logic [7:0]  written_count;
  logic [7:0]  written_count_next;
  logic [15:0] read_count;
  logic [15:0] read_count_next;
  logic        nack_seen;
  logic        nack_seen_next;
  result_t     res;
  logic        take;
  logic [7:0]  wc_inc;
  logic [15:0] rc_inc;

  function automatic logic [2:0] read_cmd(input logic [15:0] cnt, input logic [15:0] total);
    if (({1'b0, cnt} + 17'd1) == {1'b0, total}) begin
      return CMD_RNACK;
    end
    return CMD_RACK;
  endfunction

  assign ready  = !result_valid || !result_stall;
  assign take   = hold_valid && ready;
  assign wc_inc = written_count + 8'd1;
  assign rc_inc = read_count + 16'd1;

  always_comb begin
    phase_next         = phase;
    target_addr_next   = target_addr;
    write_total_next   = write_total;
    read_total_next    = read_total;
    written_count_next = written_count;
    read_count_next    = read_count;
    nack_seen_next     = nack_seen;
    res                = '0;
    unique case (phase)
      PH_IDLE: begin
        if (hold_item.op == OP_BEGIN) begin
          target_addr_next   = hold_item.slave_addr;
          write_total_next   = hold_item.send_len;
          read_total_next    = hold_item.recv_len;
          written_count_next = 8'd0;
          read_count_next    = 16'd0;
          nack_seen_next     = 1'b0;
          if (hold_item.send_len != 8'd0) begin
            res.bus_cmd  = CMD_WRITE;
            res.bus_byte = {hold_item.slave_addr, WRITE_BIT};
            phase_next   = PH_ADDR_W;
          end else if (hold_item.recv_len != 16'd0) begin
            res.bus_cmd  = CMD_WRITE;
            res.bus_byte = {hold_item.slave_addr, READ_BIT};
            phase_next   = PH_ADDR_R;
          end else begin
            res.bus_cmd = CMD_STOP;
            phase_next  = PH_STOP;
          end
        end
      end
      PH_ADDR_W: begin
        if (hold_item.op == OP_WDONE) begin
          if (hold_item.nack) begin
            nack_seen_next = 1'b1;
            res.bus_cmd    = CMD_STOP;
            phase_next     = PH_STOP;
          end else begin
            res.tx_request = 1'b1;
            phase_next     = PH_WAIT_HOST;
          end
        end
      end
      PH_WAIT_HOST: begin
        if (hold_item.op == OP_TXBYTE) begin
          res.bus_cmd  = CMD_WRITE;
          res.bus_byte = hold_item.tx_byte;
          phase_next   = PH_DATA_W;
        end
      end
      PH_DATA_W: begin
        if (hold_item.op == OP_WDONE) begin
          if (hold_item.nack) begin
            nack_seen_next = 1'b1;
            res.bus_cmd    = CMD_STOP;
            phase_next     = PH_STOP;
          end else begin
            written_count_next = wc_inc;
            if (wc_inc < write_total) begin
              res.tx_request = 1'b1;
              phase_next     = PH_WAIT_HOST;
            end else if (read_total != 16'd0) begin
              res.bus_cmd = CMD_RSTART;
              phase_next  = PH_RSTART;
            end else begin
              res.bus_cmd = CMD_STOP;
              phase_next  = PH_STOP;
            end
          end
        end
      end
      PH_RSTART: begin
        if (hold_item.op == OP_CDONE) begin
          res.bus_cmd  = CMD_WRITE;
          res.bus_byte = {target_addr, READ_BIT};
          phase_next   = PH_ADDR_R;
        end
      end
      PH_ADDR_R: begin
        if (hold_item.op == OP_WDONE) begin
          if (hold_item.nack) begin
            nack_seen_next = 1'b1;
            res.bus_cmd    = CMD_STOP;
            phase_next     = PH_STOP;
          end else begin
            res.bus_cmd = read_cmd(read_count, read_total);
            phase_next  = PH_READ;
          end
        end
      end
      PH_READ: begin
        if (hold_item.op == OP_RDONE) begin
          res.rx_byte     = hold_item.bus_rx_byte;
          res.rx_valid    = 1'b1;
          read_count_next = rc_inc;
          if (rc_inc < read_total) begin
            res.bus_cmd = read_cmd(rc_inc, read_total);
          end else begin
            res.bus_cmd = CMD_STOP;
            phase_next  = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        if (hold_item.op == OP_CDONE) begin
          res.status = nack_seen ? STATUS_NACK : STATUS_OK;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      target_addr   <= 7'd0;
      write_total   <= 8'd0;
      read_total    <= 16'd0;
      written_count <= 8'd0;
      read_count    <= 16'd0;
      nack_seen     <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        target_addr   <= target_addr_next;
        write_total   <= write_total_next;
        read_total    <= read_total_next;
        written_count <= written_count_next;
        read_count    <= read_count_next;
        nack_seen     <= nack_seen_next;
        result        <= res;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid  <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/i2c_master_transaction_sequencer_unit.sv @@
// Top level of the I2C master transaction sequencer.
//
// Sits between a host and a byte-level I2C engine. Every event (begin,
// host byte, write done, read done, command done) enters as one word on the
// item channel; each event gives exactly one result word on the result
// channel: the next bus command and byte, a host byte request, a received
// byte, and the final status on the command done after the stop.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. An accepted event waits in the input register until the
// sequencer takes it and decides it against the transaction state; the
// result is registered. One event is taken every cycle; the only
// limit is the result register, and while the receiver stalls a full result
// the input register fills and then item_stall rises, with the result held.
// Events that do not fit the current phase give an all-zero result and leave
// the state unchanged.
// Synchronous reset returns the sequencer to idle and empties both stages.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  op,
  input  logic [6:0]  slave_addr,
  input  logic [7:0]  send_len,
  input  logic [15:0] recv_len,
  input  logic [7:0]  tx_byte,
  input  logic        nack,
  input  logic [7:0]  bus_rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  bus_cmd,
  output logic [7:0]  bus_byte,
  output logic        tx_request,
  output logic [7:0]  rx_byte,
  output logic        rx_valid,
  output logic [1:0]  status
);
  import i2cmts_pkg::*;

  item_t   item;
  item_t   hold_item;
  logic    hold_valid;
  logic    ready;
  result_t result;

  assign item.op          = op;
  assign item.slave_addr  = slave_addr;
  assign item.send_len    = send_len;
  assign item.recv_len    = recv_len;
  assign item.tx_byte     = tx_byte;
  assign item.nack        = nack;
  assign item.bus_rx_byte = bus_rx_byte;

  i2cmts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .ready      (ready),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  i2cmts_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .hold_valid   (hold_valid),
    .hold_item    (hold_item),
    .ready        (ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign bus_cmd    = result.bus_cmd;
  assign bus_byte   = result.bus_byte;
  assign tx_request = result.tx_request;
  assign rx_byte    = result.rx_byte;
  assign rx_valid   = result.rx_valid;
  assign status     = result.status;

endmodule

@@ hw/rtl/i2cmts_checker.sv @@
// Port-level checker for the I2C master transaction sequencer, with its bind.
`timescale 1ns / 1ps
`include "i2c_master_transaction_sequencer_unit_defines.svh"

module i2cmts_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic [2:0]  op,
  input logic [6:0]  slave_addr,
  input logic [7:0]  send_len,
  input logic [15:0] recv_len,
  input logic [7:0]  tx_byte,
  input logic        nack,
  input logic [7:0]  bus_rx_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  bus_cmd,
  input logic [7:0]  bus_byte,
  input logic        tx_request,
  input logic [7:0]  rx_byte,
  input logic        rx_valid,
  input logic [1:0]  status
);
  import i2cmts_pkg::*;

  `I2CMTS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !result_valid, "result valid after reset")
  `I2CMTS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(bus_cmd) && $stable(bus_byte) && $stable(rx_byte) && $stable(status), "stalled result changed")
  `I2CMTS_ASSERT_SAME(a_no_stall_empty, !result_valid, !item_stall, "input stalled with empty result")
  `I2CMTS_ASSERT_SAME(a_status_alone, result_valid && status != STATUS_NONE, bus_cmd == CMD_NONE && !tx_request && !rx_valid, "status with other activity")
  `I2CMTS_ASSERT_SAME(a_rx_cmd, result_valid && rx_valid, bus_cmd == CMD_RACK || bus_cmd == CMD_RNACK || bus_cmd == CMD_STOP, "received byte without read or stop")

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_checker (.*);

@@ tb/testbench.sv @@
// Testbench for the I2C master transaction sequencer: checks each response word against a predictor.
`timescale 1ns / 1ps

module testbench;
  import i2cmts_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ADDR_W, SEQ_WAIT_HOST, SEQ_DATA_W,
    SEQ_RSTART, SEQ_ADDR_R, SEQ_READ, SEQ_STOP
  } seq_phase_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [2:0]  op;
  logic [6:0]  slave_addr;
  logic [7:0]  send_len;
  logic [15:0] recv_len;
  logic [7:0]  tx_byte;
  logic        nack;
  logic [7:0]  bus_rx_byte;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  bus_cmd;
  logic [7:0]  bus_byte;
  logic        tx_request;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic [1:0]  status;

  seq_phase_t  seq_phase = SEQ_IDLE;
  logic [6:0]  tgt_addr = '0;
  logic [7:0]  wr_total = '0;
  logic [7:0]  wr_count = '0;
  logic [15:0] rd_total = '0;
  logic [15:0] rd_count = '0;
  logic        nack_flag = 1'b0;

  result_t     predicted_responses[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;

  i2c_master_transaction_sequencer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .slave_addr   (slave_addr),
    .send_len     (send_len),
    .recv_len     (recv_len),
    .tx_byte      (tx_byte),
    .nack         (nack),
    .bus_rx_byte  (bus_rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .bus_cmd      (bus_cmd),
    .bus_byte     (bus_byte),
    .tx_request   (tx_request),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [2:0] read_command();
    return ({1'b0, rd_count} + 17'd1 == {1'b0, rd_total}) ? CMD_RNACK : CMD_RACK;
  endfunction

  function automatic result_t predict_response(input item_t w);
    result_t r;
    r = '0;
    unique case (seq_phase)
      SEQ_IDLE: if (w.op == OP_BEGIN) begin
        tgt_addr = w.slave_addr;
        wr_total = w.send_len;
        rd_total = w.recv_len;
        wr_count = '0;
        rd_count = '0;
        nack_flag = 1'b0;
        if (wr_total != 0) begin
          r.bus_cmd = CMD_WRITE;
          r.bus_byte = {tgt_addr, WRITE_BIT};
          seq_phase = SEQ_ADDR_W;
        end else if (rd_total != 0) begin
          r.bus_cmd = CMD_WRITE;
          r.bus_byte = {tgt_addr, READ_BIT};
          seq_phase = SEQ_ADDR_R;
        end else begin
          r.bus_cmd = CMD_STOP;
          seq_phase = SEQ_STOP;
        end
      end
      SEQ_ADDR_W: if (w.op == OP_WDONE) begin
        if (w.nack) begin
          nack_flag = 1'b1;
          r.bus_cmd = CMD_STOP;
          seq_phase = SEQ_STOP;
        end else begin
          r.tx_request = 1'b1;
          seq_phase = SEQ_WAIT_HOST;
        end
      end
      SEQ_WAIT_HOST: if (w.op == OP_TXBYTE) begin
        r.bus_cmd = CMD_WRITE;
        r.bus_byte = w.tx_byte;
        seq_phase = SEQ_DATA_W;
      end
      SEQ_DATA_W: if (w.op == OP_WDONE) begin
        if (w.nack) begin
          nack_flag = 1'b1;
          r.bus_cmd = CMD_STOP;
          seq_phase = SEQ_STOP;
        end else begin
          wr_count = wr_count + 8'd1;
          if (wr_count < wr_total) begin
            r.tx_request = 1'b1;
            seq_phase = SEQ_WAIT_HOST;
          end else if (rd_total != 0) begin
            r.bus_cmd = CMD_RSTART;
            seq_phase = SEQ_RSTART;
          end else begin
            r.bus_cmd = CMD_STOP;
            seq_phase = SEQ_STOP;
          end
        end
      end
      SEQ_RSTART: if (w.op == OP_CDONE) begin
        r.bus_cmd = CMD_WRITE;
        r.bus_byte = {tgt_addr, READ_BIT};
        seq_phase = SEQ_ADDR_R;
      end
      SEQ_ADDR_R: if (w.op == OP_WDONE) begin
        if (w.nack) begin
          nack_flag = 1'b1;
          r.bus_cmd = CMD_STOP;
          seq_phase = SEQ_STOP;
        end else begin
          r.bus_cmd = read_command();
          seq_phase = SEQ_READ;
        end
      end
      SEQ_READ: if (w.op == OP_RDONE) begin
        r.rx_byte = w.bus_rx_byte;
        r.rx_valid = 1'b1;
        rd_count = rd_count + 16'd1;
        if (rd_count < rd_total) begin
          r.bus_cmd = read_command();
        end else begin
          r.bus_cmd = CMD_STOP;
          seq_phase = SEQ_STOP;
        end
      end
      SEQ_STOP: if (w.op == OP_CDONE) begin
        r.status = nack_flag ? STATUS_NACK : STATUS_OK;
        seq_phase = SEQ_IDLE;
      end
      default: seq_phase = SEQ_IDLE;
    endcase
    return r;
  endfunction

  function automatic item_t make_word(input logic [2:0] w_op, input logic [6:0] w_addr,
                                      input logic [7:0] w_send, input logic [15:0] w_recv,
                                      input logic [7:0] w_tx, input logic w_nack,
                                      input logic [7:0] w_rx);
    item_t w;
    w.op = w_op;
    w.slave_addr = w_addr;
    w.send_len = w_send;
    w.recv_len = w_recv;
    w.tx_byte = w_tx;
    w.nack = w_nack;
    w.bus_rx_byte = w_rx;
    return w;
  endfunction

  function automatic item_t next_random_word();
    item_t w;
    w.op = 3'($urandom_range(0, 7));
    w.slave_addr = 7'($urandom_range(0, 127));
    w.send_len = 8'($urandom_range(0, 255));
    w.recv_len = 16'($urandom_range(0, 65535));
    w.tx_byte = 8'($urandom_range(0, 255));
    w.nack = 1'($urandom_range(0, 1));
    w.bus_rx_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      // keep noise from opening a huge read
      if (seq_phase == SEQ_IDLE && w.op == OP_BEGIN)
        w.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      unique case (seq_phase)
        SEQ_IDLE: begin
          w.op = OP_BEGIN;
          if ($urandom_range(0, 79) == 0) begin
            w.send_len = 8'($urandom_range(0, 255));
            w.recv_len = 16'($urandom_range(0, 300));
          end else begin
            w.send_len = 8'($urandom_range(0, 4));
            w.recv_len = 16'($urandom_range(0, 4));
          end
        end
        SEQ_ADDR_W, SEQ_DATA_W, SEQ_ADDR_R: begin
          w.op = OP_WDONE;
          w.nack = ($urandom_range(0, 15) == 0);
        end
        SEQ_WAIT_HOST: w.op = OP_TXBYTE;
        SEQ_READ: w.op = OP_RDONE;
        default: w.op = OP_CDONE;
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input item_t w);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(1, 20));
    end
    burst_left--;
    item_valid <= 1'b1;
    op <= w.op;
    slave_addr <= w.slave_addr;
    send_len <= w.send_len;
    recv_len <= w.recv_len;
    tx_byte <= w.tx_byte;
    nack <= w.nack;
    bus_rx_byte <= w.bus_rx_byte;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted_responses.push_back(predict_response(w));
  endtask

  task automatic drain_responses();
    item_valid <= 1'b0;
    do @(posedge clk); while (predicted_responses.size() != 0);
  endtask

  task automatic test_empty_transaction();
    send_word(make_word(OP_LAST_UNUSED, 7'h55, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF));
    send_word(make_word(OP_CDONE, 7'h55, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_BEGIN, 7'h55, 8'h00, 16'h0000, 8'hAA, 1'b1, 8'h55));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_write_then_read();
    send_word(make_word(OP_BEGIN, 7'h7F, 8'h01, 16'h0001, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_TXBYTE, 7'h00, 8'h00, 16'h0000, 8'hFF, 1'b0, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_RDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'hFF));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_read_only();
    send_word(make_word(OP_BEGIN, 7'h00, 8'h00, 16'h0002, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_RDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_RDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'hA5));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_nack_paths();
    send_word(make_word(OP_BEGIN, 7'h2A, 8'hFF, 16'hFFFF, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_BEGIN, 7'h11, 8'h01, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
    send_word(make_word(OP_FIRST_UNUSED, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF));
    send_word(make_word(OP_TXBYTE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00));
    send_word(make_word(OP_BEGIN, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF));
    send_word(make_word(OP_WDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 8'h00));
    send_word(make_word(OP_CDONE, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 149) == 0)
        drain_responses();
      send_word(next_random_word());
    end
  endtask

  always @(posedge clk) begin : check_responses
    result_t got;
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {bus_cmd, bus_byte, tx_request, rx_byte, rx_valid, status};
      if (predicted_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected word: cmd=%0d byte=%h txreq=%b rx=%h rxv=%b status=%0d",
                   got.bus_cmd, got.bus_byte, got.tx_request, got.rx_byte, got.rx_valid,
                   got.status);
      end else begin
        want = predicted_responses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: want cmd=%0d byte=%h txreq=%b rx=%h rxv=%b status=%0d %s",
                     want.bus_cmd, want.bus_byte, want.tx_request, want.rx_byte,
                     want.rx_valid, want.status,
                     $sformatf("got cmd=%0d byte=%h txreq=%b rx=%h rxv=%b status=%0d",
                               got.bus_cmd, got.bus_byte, got.tx_request, got.rx_byte,
                               got.rx_valid, got.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0)
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    unique case (stall_mode)
      STALL_NONE: result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= 1'($urandom_range(0, 1));
      default: result_stall <= cycle_count[3];
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    op = OP_BEGIN;
    slave_addr = '0;
    send_len = '0;
    recv_len = '0;
    tx_byte = '0;
    nack = 1'b0;
    bus_rx_byte = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_transaction();
    drain_responses();
    test_write_then_read();
    drain_responses();
    test_read_only();
    drain_responses();
    test_nack_paths();
    drain_responses();
    test_random_traffic();
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
